// ===== design/axrm_pkg.sv =====
package axrm_pkg;

  // cordic depth, stages beyond 24 are not run
  localparam int CORDIC_STAGES = 16;
  localparam int NUM_CORDIC    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

  // datapath step counts
  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 15;
  localparam int PIPE_LAT   = 1 + SQRT_STEPS + DIV_STEPS + 3 + NUM_CORDIC + 3 + 3 + 1;

  // angle arithmetic, q.30
  localparam int ANG_W = 36;
  localparam logic signed [ANG_W-1:0] ONE_Q30     = 36'sd1073741824;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] GAIN_Q30    = 36'sd652032875;
  localparam logic [33:0] TWO_PI_U  = 34'd6746518852;
  localparam logic [33:0] FOUR_PI_U = 34'd13493037704;

  localparam logic signed [15:0] UNIT_Q14  = 16'sd16384;
  localparam logic [31:0]        TOL_RESET = 32'd4096;

  typedef logic signed [15:0] s16_t;

  // side data travelling with the square root
  typedef struct packed {
    s16_t x;
    s16_t y;
    s16_t z;
    logic zero;
  } sq_side_t;

  // side data travelling with the angle
  typedef struct packed {
    s16_t u0;
    s16_t u1;
    s16_t u2;
    logic neg;
    logic zero;
  } cor_side_t;

  // arctangent of 2^-i, q.30
  function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = 36'sd843314857;
      1:  v = 36'sd497837830;
      2:  v = 36'sd263043837;
      3:  v = 36'sd133525159;
      4:  v = 36'sd67021687;
      5:  v = 36'sd33543516;
      6:  v = 36'sd16775851;
      7:  v = 36'sd8388437;
      8:  v = 36'sd4194283;
      9:  v = 36'sd2097149;
      10: v = 36'sd1048576;
      11: v = 36'sd524288;
      12: v = 36'sd262144;
      13: v = 36'sd131072;
      14: v = 36'sd65536;
      15: v = 36'sd32768;
      16: v = 36'sd16384;
      17: v = 36'sd8192;
      18: v = 36'sd4096;
      19: v = 36'sd2048;
      20: v = 36'sd1024;
      21: v = 36'sd512;
      22: v = 36'sd256;
      23: v = 36'sd128;
      default: v = 36'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/axrm_sqrt.sv =====
module axrm_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [47:0]        in_rad,
  input  axrm_pkg::sq_side_t in_side,
  output logic               out_valid,
  output logic [23:0]        out_root,
  output axrm_pkg::sq_side_t out_side
);
  import axrm_pkg::*;

  logic        valid_r [SQRT_STEPS];
  logic [25:0] rem_r   [SQRT_STEPS];
  logic [23:0] root_r  [SQRT_STEPS];
  logic [47:0] rad_r   [SQRT_STEPS];
  sq_side_t    side_r  [SQRT_STEPS];

  // one result bit per stage, restoring digit recurrence
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic        vld;
    logic [25:0] rem;
    logic [23:0] root;
    logic [47:0] rad;
    sq_side_t    side;
    logic [27:0] rem_sh;
    logic [27:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign vld  = in_valid;
      assign rem  = '0;
      assign root = '0;
      assign rad  = in_rad;
      assign side = in_side;
    end else begin : g_next
      assign vld  = valid_r[k-1];
      assign rem  = rem_r[k-1];
      assign root = root_r[k-1];
      assign rad  = rad_r[k-1];
      assign side = side_r[k-1];
    end

    assign rem_sh = {rem, rad[47:46]};
    assign trial  = {2'b00, root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? 26'(rem_sh - trial) : rem_sh[25:0];
      root_r[k] <= {root[22:0], ge};
      rad_r[k]  <= {rad[45:0], 2'b00};
      side_r[k] <= side;
    end
  end

  assign out_valid = valid_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1];
  assign out_side  = side_r[SQRT_STEPS-1];

endmodule

// ===== design/axrm_cordic.sv =====
module axrm_cordic (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic signed [axrm_pkg::ANG_W-1:0]     in_angle,
  input  axrm_pkg::cor_side_t                   in_side,
  output logic                                  out_valid,
  output logic signed [axrm_pkg::ANG_W-1:0]     out_cos,
  output logic signed [axrm_pkg::ANG_W-1:0]     out_sin,
  output axrm_pkg::cor_side_t                   out_side
);
  import axrm_pkg::*;

  logic                    valid_r [NUM_CORDIC];
  logic signed [ANG_W-1:0] x_r     [NUM_CORDIC];
  logic signed [ANG_W-1:0] y_r     [NUM_CORDIC];
  logic signed [ANG_W-1:0] z_r     [NUM_CORDIC];
  cor_side_t               side_r  [NUM_CORDIC];

  // one micro-rotation per stage, gain applied up front
  for (genvar i = 0; i < NUM_CORDIC; i++) begin : g_stage
    logic                    vld;
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    cor_side_t               side;
    logic signed [ANG_W-1:0] dx;
    logic signed [ANG_W-1:0] dy;
    logic                    pos;

    if (i == 0) begin : g_first
      assign vld  = in_valid;
      assign x    = GAIN_Q30;
      assign y    = '0;
      assign z    = in_angle;
      assign side = in_side;
    end else begin : g_next
      assign vld  = valid_r[i-1];
      assign x    = x_r[i-1];
      assign y    = y_r[i-1];
      assign z    = z_r[i-1];
      assign side = side_r[i-1];
    end

    assign dx  = y >>> i;
    assign dy  = x >>> i;
    assign pos = !z[ANG_W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else begin
        valid_r[i] <= vld;
      end
    end

    always_ff @(posedge clk) begin
      x_r[i]    <= pos ? x - dx : x + dx;
      y_r[i]    <= pos ? y + dy : y - dy;
      z_r[i]    <= pos ? z - atan_q30(i) : z + atan_q30(i);
      side_r[i] <= side;
    end
  end

  assign out_valid = valid_r[NUM_CORDIC-1];
  assign out_cos   = x_r[NUM_CORDIC-1];
  assign out_sin   = y_r[NUM_CORDIC-1];
  assign out_side  = side_r[NUM_CORDIC-1];

endmodule

// ===== design/axis_angle_to_rotation_matrix.sv =====
// channel   direction  handshake              payload
// input     in         start, busy            in_rot_x, in_rot_y, in_rot_z
// result    out        out_valid (strobe)     out_m00 .. out_m22, out_fell_back
// config    in         cfg_valid, cfg_ready   cfg_ortho_tolerance_sq
//
// one transaction accepted every cycle, busy stays low
// each result passes the input register, the 24-step square root,
// the 15-step axis divider, the cordic stages and the matrix and check stages
// reset clears the valid bits and loads the tolerance with 4096
// nothing stalls: each result is shown for one cycle and taken then
module axis_angle_to_rotation_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_rot_x,
  input  logic signed [15:0] in_rot_y,
  input  logic signed [15:0] in_rot_z,
  output logic               out_valid,
  output logic signed [15:0] out_m00,
  output logic signed [15:0] out_m01,
  output logic signed [15:0] out_m02,
  output logic signed [15:0] out_m10,
  output logic signed [15:0] out_m11,
  output logic signed [15:0] out_m12,
  output logic signed [15:0] out_m20,
  output logic signed [15:0] out_m21,
  output logic signed [15:0] out_m22,
  output logic               out_fell_back,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_ortho_tolerance_sq
);
  import axrm_pkg::*;

  localparam int RI [6] = '{0, 0, 0, 1, 1, 2};
  localparam int CI [6] = '{0, 1, 2, 1, 2, 2};

  logic accept;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // tolerance register
  logic [31:0] tol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_ortho_tolerance_sq;
    end
  end

  // input register
  logic s0_valid_r;
  s16_t s0_x_r, s0_y_r, s0_z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= accept;
    end
  end
  always_ff @(posedge clk) begin
    s0_x_r <= in_rot_x;
    s0_y_r <= in_rot_y;
    s0_z_r <= in_rot_z;
  end

  // squared length, then the angle by square root
  logic signed [31:0] sq_x, sq_y, sq_z;
  logic [31:0]        sum_sq;
  sq_side_t           sq_in_side;
  logic               sq_valid;
  logic [23:0]        sq_root;
  sq_side_t           sq_side;

  assign sq_x   = s0_x_r * s0_x_r;
  assign sq_y   = s0_y_r * s0_y_r;
  assign sq_z   = s0_z_r * s0_z_r;
  assign sum_sq = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
  assign sq_in_side = '{x: s0_x_r, y: s0_y_r, z: s0_z_r, zero: (sum_sq == 32'd0)};

  axrm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .in_rad    ({sum_sq, 16'h0000}),
    .in_side   (sq_in_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // axis normalisation, three restoring dividers side by side
  logic        div_valid_r [DIV_STEPS];
  logic [37:0] div_rem_r   [DIV_STEPS][3];
  logic [14:0] div_quo_r   [DIV_STEPS][3];
  logic [23:0] div_den_r   [DIV_STEPS];
  sq_side_t    div_side_r  [DIV_STEPS];

  s16_t        sq_v   [3];
  logic [37:0] div_num [3];
  assign sq_v[0] = sq_side.x;
  assign sq_v[1] = sq_side.y;
  assign sq_v[2] = sq_side.z;

  for (genvar j = 0; j < 3; j++) begin : g_num
    logic [15:0] mag;
    assign mag        = sq_v[j][15] ? 16'(-sq_v[j]) : 16'(sq_v[j]);
    assign div_num[j] = {mag, 22'h0} + 38'(sq_root >> 1);
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic        vld;
    logic [23:0] den;
    sq_side_t    side;
    logic [37:0] rem [3];
    logic [14:0] quo [3];

    if (k == 0) begin : g_first
      assign vld  = sq_valid;
      assign den  = sq_root;
      assign side = sq_side;
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rem[j] = div_num[j];
        assign quo[j] = '0;
      end
    end else begin : g_next
      assign vld  = div_valid_r[k-1];
      assign den  = div_den_r[k-1];
      assign side = div_side_r[k-1];
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rem[j] = div_rem_r[k-1][j];
        assign quo[j] = div_quo_r[k-1][j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_valid_r[k] <= 1'b0;
      end else begin
        div_valid_r[k] <= vld;
      end
    end

    always_ff @(posedge clk) begin
      div_den_r[k]  <= den;
      div_side_r[k] <= side;
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane_step
      logic [37:0] sub;
      logic        ge;
      assign sub = {14'h0, den} << (DIV_STEPS - 1 - k);
      assign ge  = (rem[j] >= sub);
      always_ff @(posedge clk) begin
        div_rem_r[k][j] <= ge ? rem[j] - sub : rem[j];
        div_quo_r[k][j] <= quo[j] | (15'(ge) << (DIV_STEPS - 1 - k));
      end
    end
  end

  // stage a: signed axis, first angle reduction
  logic        pa_valid_r;
  cor_side_t   pa_side_r;
  logic [33:0] pa_r_r;
  s16_t        pa_u [3];
  logic [33:0] pa_a30;
  sq_side_t    dv_side;

  assign dv_side = div_side_r[DIV_STEPS-1];
  assign pa_a30  = {div_den_r[DIV_STEPS-1], 10'h000};

  for (genvar j = 0; j < 3; j++) begin : g_axis
    logic [14:0] q;
    logic [14:0] sat;
    s16_t        v;
    assign q    = div_quo_r[DIV_STEPS-1][j];
    assign sat  = (q > 15'(UNIT_Q14)) ? 15'(UNIT_Q14) : q;
    assign v    = (j == 0) ? dv_side.x : ((j == 1) ? dv_side.y : dv_side.z);
    assign pa_u[j] = v[15] ? -s16_t'({1'b0, sat}) : s16_t'({1'b0, sat});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_valid_r <= 1'b0;
    end else begin
      pa_valid_r <= div_valid_r[DIV_STEPS-1];
    end
  end
  always_ff @(posedge clk) begin
    pa_side_r <= '{u0: pa_u[0], u1: pa_u[1], u2: pa_u[2], neg: 1'b0, zero: dv_side.zero};
    pa_r_r    <= (pa_a30 >= FOUR_PI_U) ? pa_a30 - FOUR_PI_U : pa_a30;
  end

  // stage b: second reduction, wrap to [-pi, pi]
  logic                    pb_valid_r;
  cor_side_t               pb_side_r;
  logic signed [ANG_W-1:0] pb_ang_r;
  logic [33:0]             pb_r2;
  logic signed [ANG_W-1:0] pb_rs;

  assign pb_r2 = (pa_r_r >= TWO_PI_U) ? pa_r_r - TWO_PI_U : pa_r_r;
  assign pb_rs = $signed({2'b00, pb_r2});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_valid_r <= 1'b0;
    end else begin
      pb_valid_r <= pa_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    pb_side_r <= pa_side_r;
    pb_ang_r  <= (pb_rs > PI_Q30) ? pb_rs - TWO_PI_Q30 : pb_rs;
  end

  // stage c: fold into [-pi/2, pi/2]
  logic                    pc_valid_r;
  cor_side_t               pc_side_r;
  logic signed [ANG_W-1:0] pc_ang_r;
  cor_side_t               pc_side_nxt;
  logic signed [ANG_W-1:0] pc_ang_nxt;

  always_comb begin
    pc_side_nxt = pb_side_r;
    pc_ang_nxt  = pb_ang_r;
    if (pb_ang_r > HALF_PI_Q30) begin
      pc_ang_nxt      = PI_Q30 - pb_ang_r;
      pc_side_nxt.neg = 1'b1;
    end else if (pb_ang_r < -HALF_PI_Q30) begin
      pc_ang_nxt      = -PI_Q30 - pb_ang_r;
      pc_side_nxt.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_valid_r <= 1'b0;
    end else begin
      pc_valid_r <= pb_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    pc_side_r <= pc_side_nxt;
    pc_ang_r  <= pc_ang_nxt;
  end

  // sine and cosine
  logic                    co_valid;
  logic signed [ANG_W-1:0] co_cos;
  logic signed [ANG_W-1:0] co_sin;
  cor_side_t               co_side;

  axrm_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pc_valid_r),
    .in_angle  (pc_ang_r),
    .in_side   (pc_side_r),
    .out_valid (co_valid),
    .out_cos   (co_cos),
    .out_sin   (co_sin),
    .out_side  (co_side)
  );

  // m1: one minus cosine, outer product of the axis less |u|^2 on the diagonal
  logic                    m1_valid_r;
  logic                    m1_zero_r;
  s16_t                    m1_u_r  [3];
  logic signed [ANG_W-1:0] m1_t_r;
  logic signed [ANG_W-1:0] m1_sn_r;
  logic signed [32:0]      m1_uu_r [9];
  s16_t                    co_u    [3];
  logic signed [31:0]      uprod   [9];
  logic signed [32:0]      n2;
  logic signed [32:0]      uu_nxt  [9];
  logic signed [ANG_W-1:0] cs;

  assign co_u[0] = co_side.u0;
  assign co_u[1] = co_side.u1;
  assign co_u[2] = co_side.u2;
  assign cs      = co_side.neg ? -co_cos : co_cos;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        uprod[i*3+j] = co_u[i] * co_u[j];
      end
    end
    n2 = 33'(uprod[0]) + 33'(uprod[4]) + 33'(uprod[8]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        uu_nxt[i*3+j] = 33'(uprod[i*3+j]) - ((i == j) ? n2 : 33'sd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else begin
      m1_valid_r <= co_valid;
    end
  end
  always_ff @(posedge clk) begin
    m1_zero_r <= co_side.zero;
    m1_u_r    <= co_u;
    m1_t_r    <= ONE_Q30 - cs;
    m1_sn_r   <= co_sin;
    m1_uu_r   <= uu_nxt;
  end

  // m2: skew term times sine, outer term times one minus cosine
  logic               m2_valid_r;
  logic               m2_zero_r;
  logic signed [39:0] m2_a_r [9];
  logic signed [39:0] m2_b_r [9];
  logic signed [16:0] kmat   [9];
  logic signed [52:0] ks     [9];
  logic signed [68:0] ut     [9];

  assign kmat[0] = 17'sd0;
  assign kmat[1] = -17'(m1_u_r[2]);
  assign kmat[2] = 17'(m1_u_r[1]);
  assign kmat[3] = 17'(m1_u_r[2]);
  assign kmat[4] = 17'sd0;
  assign kmat[5] = -17'(m1_u_r[0]);
  assign kmat[6] = -17'(m1_u_r[1]);
  assign kmat[7] = 17'(m1_u_r[0]);
  assign kmat[8] = 17'sd0;

  for (genvar e = 0; e < 9; e++) begin : g_terms
    assign ks[e] = kmat[e] * m1_sn_r;
    assign ut[e] = m1_uu_r[e] * m1_t_r;
    always_ff @(posedge clk) begin
      m2_a_r[e] <= 40'((ks[e] + 53'sd8192) >>> 14);
      m2_b_r[e] <= 40'((ut[e] + 69'sd134217728) >>> 28);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
    end else begin
      m2_valid_r <= m1_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    m2_zero_r <= m1_zero_r;
  end

  // m3: sum, round to q1.14 and saturate
  logic m3_valid_r;
  logic m3_zero_r;
  s16_t m3_m_r [9];

  for (genvar e = 0; e < 9; e++) begin : g_entry
    logic signed [40:0] acc;
    logic signed [24:0] rnd;
    s16_t               sat;
    assign acc = 41'(m2_a_r[e]) + 41'(m2_b_r[e]) + ((e % 4 == 0) ? 41'sd1073741824 : 41'sd0);
    assign rnd = 25'((acc + 41'sd32768) >>> 16);
    assign sat = (rnd > 25'sd16384) ? UNIT_Q14 :
                 ((rnd < -25'sd16384) ? -UNIT_Q14 : rnd[15:0]);
    always_ff @(posedge clk) begin
      m3_m_r[e] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_valid_r <= 1'b0;
    end else begin
      m3_valid_r <= m2_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    m3_zero_r <= m2_zero_r;
  end

  // c1: upper triangle of m times m transpose, less identity
  logic               c1_valid_r;
  logic               c1_zero_r;
  s16_t               c1_m_r [9];
  logic signed [33:0] c1_d_r [6];

  for (genvar p = 0; p < 6; p++) begin : g_dot
    logic signed [31:0] pr [3];
    logic signed [33:0] dot;
    for (genvar l = 0; l < 3; l++) begin : g_term
      assign pr[l] = m3_m_r[RI[p]*3+l] * m3_m_r[CI[p]*3+l];
    end
    assign dot = 34'(pr[0]) + 34'(pr[1]) + 34'(pr[2]) -
                 ((RI[p] == CI[p]) ? 34'sd268435456 : 34'sd0);
    always_ff @(posedge clk) begin
      c1_d_r[p] <= dot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_valid_r <= 1'b0;
    end else begin
      c1_valid_r <= m3_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    c1_zero_r <= m3_zero_r;
    c1_m_r    <= m3_m_r;
  end

  // c2: squared deviations
  logic        c2_valid_r;
  logic        c2_zero_r;
  s16_t        c2_m_r  [9];
  logic [63:0] c2_sq_r [6];

  for (genvar p = 0; p < 6; p++) begin : g_sq
    logic signed [67:0] sqd;
    assign sqd = c1_d_r[p] * c1_d_r[p];
    always_ff @(posedge clk) begin
      c2_sq_r[p] <= sqd[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_valid_r <= 1'b0;
    end else begin
      c2_valid_r <= c1_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    c2_zero_r <= c1_zero_r;
    c2_m_r    <= c1_m_r;
  end

  // c3: squared frobenius error, off-diagonal terms count twice
  logic        c3_valid_r;
  logic        c3_zero_r;
  s16_t        c3_m_r [9];
  logic [63:0] c3_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_valid_r <= 1'b0;
    end else begin
      c3_valid_r <= c2_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    c3_zero_r <= c2_zero_r;
    c3_m_r    <= c2_m_r;
    c3_err_r  <= c2_sq_r[0] + c2_sq_r[3] + c2_sq_r[5] +
                 ((c2_sq_r[1] + c2_sq_r[2] + c2_sq_r[4]) << 1);
  end

  // output register, identity on zero input or failed check
  logic        out_valid_r;
  logic        out_fb_r;
  s16_t        out_m_r [9];
  logic        fail;

  assign fail = c3_zero_r || (c3_err_r > {4'h0, tol_r, 28'h0000000});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c3_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    out_fb_r <= fail;
    for (int e = 0; e < 9; e++) begin
      if (fail) begin
        out_m_r[e] <= (e % 4 == 0) ? UNIT_Q14 : 16'sd0;
      end else begin
        out_m_r[e] <= c3_m_r[e];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_fell_back = out_fb_r;
  assign out_m00       = out_m_r[0];
  assign out_m01       = out_m_r[1];
  assign out_m02       = out_m_r[2];
  assign out_m10       = out_m_r[3];
  assign out_m11       = out_m_r[4];
  assign out_m12       = out_m_r[5];
  assign out_m20       = out_m_r[6];
  assign out_m21       = out_m_r[7];
  assign out_m22       = out_m_r[8];

  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("result missing after pipeline latency");

  // no result without a matching transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_LAT))
    else $error("result without accepted transaction");

  // zero vector always falls back
  a_zero_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_rot_x == 16'sd0 && in_rot_y == 16'sd0 && in_rot_z == 16'sd0
    |-> ##PIPE_LAT out_fell_back)
    else $error("zero vector did not fall back");

  // diagonal stays within unit range
  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_m00 <= UNIT_Q14 && out_m00 >= -UNIT_Q14 &&
                  out_m11 <= UNIT_Q14 && out_m11 >= -UNIT_Q14 &&
                  out_m22 <= UNIT_Q14 && out_m22 >= -UNIT_Q14)
    else $error("diagonal entry out of range");

endmodule
